/* src/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the barometer compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OSS = 2'd0,
    REG_CAL_A = 2'd1,
    REG_CAL_B = 2'd2,
    REG_CAL_C = 2'd3
  } reg_idx_e;

  localparam logic [31:0] K4000 = 32'd4000;
  localparam logic [31:0] K32768 = 32'd32768;
  localparam logic [31:0] K50000 = 32'd50000;
  localparam logic [31:0] KSign = 32'h8000_0000;
  localparam logic [31:0] K3038 = 32'd3038;
  localparam logic [31:0] KNeg7357 = 32'hFFFF_E343;
  localparam logic [31:0] K3791 = 32'd3791;

  typedef struct packed {
    logic [15:0] ut;
    logic [18:0] up;
  } raw_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] press;
    logic        err;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T0,
    ST_TDIV,
    ST_T1,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_PDIV,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_DONE
  } st_e;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    asr32 = 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

endpackage

/* src/baro_pressure_temp_compensation_top.sv */
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_top
// Barometer temperature and pressure compensation.
// ----------------------------------------------------------------------------
// A request is queued at the front and computed by a sequencer that shares
// one 32x32 multiplier and one radix-2 divider; an item runs two divisions,
// and stops early when a divisor is zero.
// The result register lets the next request start while a result waits.
module baro_pressure_temp_compensation_top
  import bpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [15:0]         raw_temperature_i,
  input  logic [18:0]         raw_pressure_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  temperature_tenths_o,
  output logic signed [31:0]  pressure_pa_o,
  output logic                div_error_o
);

  logic [1:0]  oss_q;
  logic [47:0] cal_a_q, cal_b_q;
  logic [63:0] cal_c_q;
  raw_t in_raw, q_raw;
  logic q_valid, q_ready;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q <= '0;
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_OSS: oss_q <= cfg_data_i[1:0];
        REG_CAL_A: cal_a_q <= cfg_data_i[47:0];
        REG_CAL_B: cal_b_q <= cfg_data_i[47:0];
        REG_CAL_C: cal_c_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_raw.ut = raw_temperature_i;
  assign in_raw.up = raw_pressure_i;

  bpc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_raw),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_raw)
  );

  bpc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .in_data_i  (q_raw),
    .oss_i      (oss_q),
    .cal_a_i    (cal_a_q),
    .cal_b_i    (cal_b_q),
    .cal_c_i    (cal_c_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (res)
  );

  assign temperature_tenths_o = res.temp;
  assign pressure_pa_o = res.press;
  assign div_error_o = res.err;

endmodule

/* src/bpc_queue.sv */
// ----------------------------------------------------------------------------
// bpc_queue
// Two-entry queue between the input front and the compute back.
// ----------------------------------------------------------------------------
module bpc_queue
  import bpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  raw_t in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output raw_t out_data_o
);

  raw_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o = mem_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* src/bpc_divider.sv */
// ----------------------------------------------------------------------------
// bpc_divider
// Unsigned 32-bit radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_divider
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic [31:0] rem_q, quo_q, den_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q, quo_q[31]};
  assign trial = shifted - {1'b0, den_q};
  assign quo_o = quo_q;
  assign done_o = busy_q && (cnt_q == 6'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 6'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd32;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 6'd1;
    end
  end

endmodule

/* src/bpc_core.sv */
// ----------------------------------------------------------------------------
// bpc_core
// Sequenced compensation datapath with one shared multiplier and divider.
// ----------------------------------------------------------------------------
module bpc_core
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  raw_t        in_data_i,
  input  logic [1:0]  oss_i,
  input  logic [47:0] cal_a_i,
  input  logic [47:0] cal_b_i,
  input  logic [63:0] cal_c_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o
);

  st_e st_q, st_d;
  raw_t raw_q;
  logic [31:0] b6_q, sq_q, x3_q, b3_q, b7_q, p_q, acc_q, temp_q, t_q;
  logic        neg_q;
  res_t res_q;
  logic res_v_q;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  logic [31:0] ma, mb, prod;
  logic        div_start, div_done;
  logic [31:0] div_num, div_den, div_quo;
  logic [31:0] x1t, dent, numt, tmp1, b4t;

  assign ac1 = sx16(cal_a_i[47:32]);
  assign ac2 = sx16(cal_a_i[31:16]);
  assign ac3 = sx16(cal_a_i[15:0]);
  assign ac4 = {16'd0, cal_b_i[47:32]};
  assign ac5 = {16'd0, cal_b_i[31:16]};
  assign ac6 = {16'd0, cal_b_i[15:0]};
  assign b1 = sx16(cal_c_i[63:48]);
  assign b2 = sx16(cal_c_i[47:32]);
  assign mc = sx16(cal_c_i[31:16]);
  assign md = sx16(cal_c_i[15:0]);

  assign prod = ma * mb;

  bpc_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  assign in_ready_o = (st_q == ST_IDLE);
  assign out_valid_o = res_v_q;
  assign out_data_o = res_q;

  always_comb begin
    st_d = st_q;
    ma = '0;
    mb = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    x1t = asr32(acc_q, 15);
    dent = x1t + md;
    numt = mc << 11;
    tmp1 = '0;
    b4t = '0;
    unique case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_T0;
      ST_T0: begin
        ma = {16'd0, raw_q.ut} - ac6;
        mb = ac5;
        st_d = ST_TDIV;
      end
      ST_TDIV: begin
        div_start = 1'b1;
        div_num = numt[31] ? (32'd0 - numt) : numt;
        div_den = dent[31] ? (32'd0 - dent) : dent;
        st_d = (dent == 32'd0) ? ST_DONE : ST_T1;
      end
      ST_T1: if (div_done) st_d = ST_P0;
      ST_P0: begin
        ma = b6_q;
        mb = b6_q;
        st_d = ST_P1;
      end
      ST_P1: begin
        ma = b2;
        mb = sq_q;
        st_d = ST_P2;
      end
      ST_P2: begin
        ma = ac2;
        mb = b6_q;
        st_d = ST_P3;
      end
      ST_P3: begin
        ma = ac3;
        mb = b6_q;
        st_d = ST_P4;
      end
      ST_P4: begin
        ma = b1;
        mb = sq_q;
        st_d = ST_PDIV;
      end
      ST_PDIV: begin
        ma = ac4;
        mb = x3_q + K32768;
        b4t = prod >> 15;
        if (b4t == 32'd0) begin
          st_d = ST_DONE;
        end else begin
          div_start = 1'b1;
          div_den = b4t;
          div_num = ((b7_q & KSign) == 32'd0) ? (b7_q << 1) : b7_q;
          st_d = ST_F0;
        end
      end
      ST_F0: if (div_done) st_d = ST_F1;
      ST_F1: begin
        tmp1 = asr32(p_q, 8);
        ma = tmp1;
        mb = tmp1;
        st_d = ST_F2;
      end
      ST_F2: begin
        ma = acc_q;
        mb = K3038;
        st_d = ST_DONE;
      end
      ST_DONE: if (!res_v_q || out_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: if (in_valid_i) raw_q <= in_data_i;
      ST_T0: acc_q <= prod;
      ST_TDIV: begin
        neg_q <= numt[31] ^ dent[31];
        t_q <= x1t;
        temp_q <= (dent == 32'd0) ? 32'd1 : 32'd0;
      end
      ST_T1: if (div_done) begin
        b6_q <= (t_q + (neg_q ? (32'd0 - div_quo) : div_quo)) - K4000;
        temp_q <= asr32(t_q + (neg_q ? (32'd0 - div_quo) : div_quo) + 32'd8, 4);
      end
      ST_P0: sq_q <= asr32(prod, 12);
      ST_P1: acc_q <= asr32(prod, 11);
      ST_P2: begin
        b3_q <= asr32(((ac1 * 32'd4 + acc_q + asr32(prod, 11)) << oss_i) + 32'd2, 2);
      end
      ST_P3: begin
        acc_q <= prod;
        b7_q <= (({13'd0, raw_q.up}) - b3_q) * (K50000 >> oss_i);
      end
      ST_P4: x3_q <= asr32(asr32(acc_q, 13) + asr32(prod, 16) + 32'd2, 2);
      ST_F0: if (div_done) p_q <= ((b7_q & KSign) == 32'd0) ? div_quo : (div_quo << 1);
      ST_F1: acc_q <= prod;
      ST_F2: acc_q <= prod;
      default: ;
    endcase
  end

  // Pressure is finished in ST_DONE from the last product held in acc_q.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      res_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (res_v_q && out_ready_i) res_v_q <= 1'b0;
      if (st_q == ST_DONE && (!res_v_q || out_ready_i)) res_v_q <= 1'b1;
    end
  end

  logic [31:0] p_fin;
  assign p_fin = p_q + asr32(asr32(acc_q, 16) + asr32(KNeg7357 * p_q, 16) + K3791, 4);

  logic err_q;
  always_ff @(posedge clk_i) begin
    if (st_q == ST_TDIV) err_q <= (dent == 32'd0);
    else if (st_q == ST_PDIV) err_q <= (b4t == 32'd0);
    if (st_q == ST_DONE && (!res_v_q || out_ready_i)) begin
      res_q.err <= err_q;
      res_q.temp <= err_q ? 32'd0 : temp_q;
      res_q.press <= err_q ? 32'd0 : p_fin;
    end
  end

endmodule
